// ===== hw/rtl/skf_pkg.sv =====
// Shared constants, types and helper functions of the scalar Kalman filter.
// Used by the channel interfaces, the serial arithmetic units and the top level.
// Depends on nothing.
package skf_pkg;

   // Field and arithmetic widths fixed by the item format
   localparam int DATA_WIDTH_DEF = 32;
   localparam int FIELD_W        = 32;
   localparam int VAR_W          = 31;
   localparam int MUL_W          = 32;
   localparam int MUL_DIG_W      = 2;
   localparam int DIV_W          = 32;
   localparam int CSR_IDX_W      = 8;

   // Reset values of the filter registers and of the variance state
   localparam logic [VAR_W-1:0] VAR_RESET = 31'd65536;

   // Register indexes of the configuration channel
   localparam logic [CSR_IDX_W-1:0] CSR_AR_COEF   = 8'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MEAN_OFS  = 8'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_OBS_NOISE = 8'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_STA_NOISE = 8'd3;

   // Serial multiplier command and status
   typedef struct packed {
      logic             start;
      logic [MUL_W-1:0] a;
      logic [MUL_W-1:0] b;
   } mul_req_type;

   typedef struct packed {
      logic               busy;
      logic [2*MUL_W-1:0] product;
   } mul_rsp_type;

   // Serial divider command and status
   typedef struct packed {
      logic               start;
      logic [2*DIV_W-1:0] dividend;
      logic [DIV_W-1:0]   divisor;
   } div_req_type;

   typedef struct packed {
      logic             busy;
      logic [DIV_W-1:0] quotient;
   } div_rsp_type;

   // Result of a clip: limited value and a flag for a hit on either limit
   typedef struct packed {
      logic [63:0] value;
      logic        hit;
   } clip_res_type;

   function automatic clip_res_type clip_s64(input logic signed [63:0] v,
                                             input logic signed [63:0] lo,
                                             input logic signed [63:0] hi);
      clip_res_type r;
      r.value = v;
      r.hit   = 1'b0;
      if (v < lo) begin
         r.value = lo;
         r.hit   = 1'b1;
      end else if (v > hi) begin
         r.value = hi;
         r.hit   = 1'b1;
      end
      return r;
   endfunction

   // Magnitude of a signed field; the most negative value maps to 2^31
   function automatic logic [FIELD_W-1:0] mag32(input logic signed [FIELD_W-1:0] v);
      return v[FIELD_W-1] ? (~v + 32'd1) : v;
   endfunction

endpackage

// ===== hw/rtl/skf_req_if.sv =====
// Input channel of the scalar Kalman filter: one observation per transfer.
// Depends on skf_pkg.
interface skf_req_if;
   logic                                valid;
   logic                                ready;
   logic signed [skf_pkg::FIELD_W-1:0]  observation;
   logic                                series_start;

   modport source (output valid, observation, series_start, input ready);
   modport sink   (input valid, observation, series_start, output ready);
endinterface

// ===== hw/rtl/skf_rsp_if.sv =====
// Result channel of the scalar Kalman filter: filtered mean and variance.
// Depends on skf_pkg.
interface skf_rsp_if;
   logic                                valid;
   logic                                ready;
   logic signed [skf_pkg::FIELD_W-1:0]  filtered_mean;
   logic        [skf_pkg::VAR_W-1:0]    filtered_var;
   logic                                saturated;

   modport source (output valid, filtered_mean, filtered_var, saturated, input ready);
   modport sink   (input valid, filtered_mean, filtered_var, saturated, output ready);
endinterface

// ===== hw/rtl/skf_csr_if.sv =====
// Register write channel of the scalar Kalman filter: index and write data.
// Depends on skf_pkg.
interface skf_csr_if;
   logic                              valid;
   logic                              ready;
   logic [skf_pkg::CSR_IDX_W-1:0]     index;
   logic [skf_pkg::FIELD_W-1:0]       wdata;

   modport source (output valid, index, wdata, input ready);
   modport sink   (input valid, index, wdata, output ready);
endinterface

// ===== hw/rtl/skf_mul_serial.sv =====
// Unsigned shift-add multiplier, one radix-4 digit of operand b per cycle.
// Depends on skf_pkg (widths, command and status structs).
module skf_mul_serial (
   input  logic                 clock,
   input  logic                 reset,
   input  skf_pkg::mul_req_type req,
   output skf_pkg::mul_rsp_type rsp
);

   localparam int OP_W   = skf_pkg::MUL_W;
   localparam int DIG_W  = skf_pkg::MUL_DIG_W;
   localparam int STEPS  = OP_W / DIG_W;
   localparam int CNT_W  = $clog2(STEPS);
   localparam int PART_W = OP_W + DIG_W;
   localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(STEPS - 1);

   logic [2*OP_W-1:0] acc_ff, acc_in;
   logic [OP_W-1:0]   a_ff, a_in;
   logic [PART_W-1:0] a3_ff, a3_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              busy_ff, busy_in;
   logic [PART_W-1:0] part;
   logic [PART_W-1:0] sum;

   // Select the digit multiple of a
   always_comb begin
      case (acc_ff[DIG_W-1:0])
         2'd0:    part = '0;
         2'd1:    part = PART_W'(a_ff);
         2'd2:    part = PART_W'({a_ff, 1'b0});
         2'd3:    part = a3_ff;
         default: part = '0;
      endcase
      sum = PART_W'(acc_ff[2*OP_W-1:OP_W]) + part;
   end

   // Load operands on start, then add and shift one digit per cycle
   always_comb begin
      acc_in  = acc_ff;
      a_in    = a_ff;
      a3_in   = a3_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      if (busy_ff) begin
         acc_in = {sum, acc_ff[OP_W-1:DIG_W]};
         cnt_in = cnt_ff + CNT_W'(1);
         if (cnt_ff == LAST_STEP) begin
            busy_in = 1'b0;
         end
      end else if (req.start) begin
         acc_in  = {{OP_W{1'b0}}, req.b};
         a_in    = req.a;
         a3_in   = PART_W'(req.a) + PART_W'({req.a, 1'b0});
         cnt_in  = '0;
         busy_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      acc_ff <= acc_in;
      a_ff   <= a_in;
      a3_ff  <= a3_in;
   end

   assign rsp.busy    = busy_ff;
   assign rsp.product = acc_ff;

endmodule

// ===== hw/rtl/skf_div_serial.sv =====
// Restoring divider, one quotient bit per cycle; the quotient must fit DIV_W bits.
// Depends on skf_pkg (widths, command and status structs).
module skf_div_serial (
   input  logic                 clock,
   input  logic                 reset,
   input  skf_pkg::div_req_type req,
   output skf_pkg::div_rsp_type rsp
);

   localparam int DW    = skf_pkg::DIV_W;
   localparam int CNT_W = $clog2(DW);
   localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(DW - 1);

   logic [DW-1:0]    rem_ff, rem_in;
   logic [DW-1:0]    quo_ff, quo_in;
   logic [DW-1:0]    dvs_ff, dvs_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic [DW:0]      trial;
   logic [DW:0]      diff;
   logic             fits;

   // Bring down the next dividend bit and try the subtraction
   always_comb begin
      trial = {rem_ff, quo_ff[DW-1]};
      diff  = trial - {1'b0, dvs_ff};
      fits  = (trial >= {1'b0, dvs_ff});
   end

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      if (busy_ff) begin
         rem_in = fits ? diff[DW-1:0] : trial[DW-1:0];
         quo_in = {quo_ff[DW-2:0], fits};
         cnt_in = cnt_ff + CNT_W'(1);
         if (cnt_ff == LAST_STEP) begin
            busy_in = 1'b0;
         end
      end else if (req.start) begin
         rem_in  = req.dividend[2*DW-1:DW];
         quo_in  = req.dividend[DW-1:0];
         dvs_in  = req.divisor;
         cnt_in  = '0;
         busy_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

   assign rsp.busy     = busy_ff;
   assign rsp.quotient = quo_ff;

endmodule

// ===== hw/rtl/scalar_kalman_filter_unit.sv =====
// Scalar Kalman filter, forward pass, one observation in and one estimate out.
//
// Channels: req_chan takes an observation and a series start flag, rsp_chan
// returns the filtered mean, the filtered variance and a clip flag, csr_chan
// writes the four filter registers (AR coefficient, mean offset, observation
// noise, state noise). All use valid/ready; csr_chan is always ready. The user
// writes csr_chan only while no item is in flight; the block does not enforce it.
// Each item passes three times through the radix-4 serial multipliers and
// once through the bit-serial dividers; a zero innovation denominator skips
// the division. A new item is taken once the previous one has left the
// arithmetic.
// Reset: clears the registers to their defaults, mean to 0, variance to 1.0.
// Stall: the result sits in an output register; the next item is accepted
// while it waits, and its own result holds in the last stage until the
// register frees up.
// Depends on skf_pkg, the channel interfaces, skf_mul_serial, skf_div_serial.
module scalar_kalman_filter_unit #(
   parameter int DATA_WIDTH = skf_pkg::DATA_WIDTH_DEF
) (
   input  logic       clock,
   input  logic       reset,
   skf_req_if.sink    req_chan,
   skf_rsp_if.source  rsp_chan,
   skf_csr_if.sink    csr_chan
);

   localparam int FW    = skf_pkg::FIELD_W;
   localparam int VW    = skf_pkg::VAR_W;
   localparam int SAT_W = (DATA_WIDTH < 32) ? DATA_WIDTH : 32;
   localparam logic signed [63:0] MEAN_MAX = (64'sd1 <<< (SAT_W - 1)) - 64'sd1;
   localparam logic signed [63:0] MEAN_MIN = -MEAN_MAX - 64'sd1;
   localparam logic signed [63:0] VAR_MAX  = MEAN_MAX;

   typedef enum logic [3:0] {
      S_IDLE, S_PRED, S_PRED_WAIT, S_VAR, S_VAR_WAIT,
      S_GAIN, S_GAIN_WAIT, S_DIV, S_DIV_WAIT, S_FIN
   } state_type;

   state_type state_ff, state_in;

   // Filter registers
   logic signed [FW-1:0] ar_ff, ar_in;
   logic signed [FW-1:0] ofs_ff, ofs_in;
   logic [VW-1:0]        rnoise_ff, rnoise_in;
   logic [VW-1:0]        qnoise_ff, qnoise_in;

   // Filter state
   logic signed [SAT_W-1:0] mean_ff, mean_in;
   logic [VW-1:0]           var_ff, var_in;

   // Per-item working registers
   logic signed [FW-1:0] y_ff, y_in;
   logic signed [FW-1:0] at_ff, at_in;
   logic signed [FW-1:0] vt_ff, vt_in;
   logic [VW-1:0]        phi2_ff, phi2_in;
   logic [VW-1:0]        pt_ff, pt_in;
   logic [FW-1:0]        den_ff, den_in;
   logic                 dz_ff, dz_in;
   logic                 neg_ff, neg_in;
   logic                 sat_ff, sat_in;

   // Output register
   logic                 rsp_valid_ff, rsp_valid_in;
   logic signed [FW-1:0] rsp_mean_ff, rsp_mean_in;
   logic [VW-1:0]        rsp_var_ff, rsp_var_in;
   logic                 rsp_sat_ff, rsp_sat_in;

   skf_pkg::mul_req_type mul_a_req, mul_b_req;
   skf_pkg::mul_rsp_type mul_a_rsp, mul_b_rsp;
   skf_pkg::div_req_type div_a_req, div_b_req;
   skf_pkg::div_rsp_type div_a_rsp, div_b_rsp;

   logic signed [FW-1:0] mean_ext;
   logic signed [63:0]   pred_prod;
   logic signed [63:0]   innov;
   logic signed [63:0]   upd;
   logic signed [63:0]   newm_sum;
   logic [VW-1:0]        newv;
   logic                 mul_busy;
   logic                 div_busy;
   logic                 out_free;
   skf_pkg::clip_res_type q_clip, at_clip, phi2_clip, pt_clip, vt_clip, newm_clip;

   skf_mul_serial u_mul_a (.clock(clock), .reset(reset), .req(mul_a_req), .rsp(mul_a_rsp));
   skf_mul_serial u_mul_b (.clock(clock), .reset(reset), .req(mul_b_req), .rsp(mul_b_rsp));
   skf_div_serial u_div_a (.clock(clock), .reset(reset), .req(div_a_req), .rsp(div_a_rsp));
   skf_div_serial u_div_b (.clock(clock), .reset(reset), .req(div_b_req), .rsp(div_b_rsp));

   // Stage arithmetic: each result is only taken in the state that owns it
   always_comb begin
      mean_ext  = FW'(mean_ff);
      mul_busy  = mul_a_rsp.busy | mul_b_rsp.busy;
      div_busy  = div_a_rsp.busy | div_b_rsp.busy;
      out_free  = ~rsp_valid_ff | rsp_chan.ready;
      q_clip    = skf_pkg::clip_s64($signed(64'(qnoise_ff)), 64'sd0, VAR_MAX);
      pred_prod = neg_ff ? -$signed(mul_a_rsp.product) : $signed(mul_a_rsp.product);
      at_clip   = skf_pkg::clip_s64(pred_prod >>> 16, MEAN_MIN, MEAN_MAX);
      phi2_clip = skf_pkg::clip_s64($signed({16'b0, mul_b_rsp.product[63:16]}),
                                    64'sd0, VAR_MAX);
      pt_clip   = skf_pkg::clip_s64($signed({16'b0, mul_a_rsp.product[63:16]})
                                    + $signed(64'(qnoise_ff)), 64'sd0, VAR_MAX);
      innov     = 64'(y_ff) - 64'(ofs_ff) - 64'(at_ff);
      vt_clip   = skf_pkg::clip_s64(innov, MEAN_MIN, MEAN_MAX);
      if (dz_ff) begin
         upd  = 64'sd0;
         newv = pt_ff;
      end else begin
         upd  = vt_ff[FW-1] ? -$signed({32'b0, div_a_rsp.quotient})
                            : $signed({32'b0, div_a_rsp.quotient});
         newv = pt_ff - div_b_rsp.quotient[VW-1:0];
      end
      newm_sum  = 64'(at_ff) + upd;
      newm_clip = skf_pkg::clip_s64(newm_sum, MEAN_MIN, MEAN_MAX);
   end

   // Sequencer: register writes, item control and the output register
   always_comb begin
      state_in     = state_ff;
      ar_in        = ar_ff;
      ofs_in       = ofs_ff;
      rnoise_in    = rnoise_ff;
      qnoise_in    = qnoise_ff;
      mean_in      = mean_ff;
      var_in       = var_ff;
      y_in         = y_ff;
      at_in        = at_ff;
      vt_in        = vt_ff;
      phi2_in      = phi2_ff;
      pt_in        = pt_ff;
      den_in       = den_ff;
      dz_in        = dz_ff;
      neg_in       = neg_ff;
      sat_in       = sat_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_chan.ready;
      rsp_mean_in  = rsp_mean_ff;
      rsp_var_in   = rsp_var_ff;
      rsp_sat_in   = rsp_sat_ff;
      mul_a_req    = '0;
      mul_b_req    = '0;
      div_a_req    = '0;
      div_b_req    = '0;

      // Register writes; unknown indexes drop
      if (csr_chan.valid) begin
         case (csr_chan.index)
            skf_pkg::CSR_AR_COEF:   ar_in     = csr_chan.wdata;
            skf_pkg::CSR_MEAN_OFS:  ofs_in    = csr_chan.wdata;
            skf_pkg::CSR_OBS_NOISE: rnoise_in = csr_chan.wdata[VW-1:0];
            skf_pkg::CSR_STA_NOISE: qnoise_in = csr_chan.wdata[VW-1:0];
            default: ;
         endcase
      end

      case (state_ff)
         S_IDLE: begin
            // Take the observation; a series start reloads the prior first
            if (req_chan.valid) begin
               y_in   = req_chan.observation;
               sat_in = 1'b0;
               dz_in  = 1'b0;
               if (req_chan.series_start) begin
                  mean_in = '0;
                  var_in  = q_clip.value[VW-1:0];
                  sat_in  = q_clip.hit;
               end
               state_in = S_PRED;
            end
         end
         S_PRED: begin
            // Issue phi*m and phi*phi on magnitudes
            mul_a_req.start = 1'b1;
            mul_a_req.a     = skf_pkg::mag32(ar_ff);
            mul_a_req.b     = skf_pkg::mag32(mean_ext);
            mul_b_req.start = 1'b1;
            mul_b_req.a     = skf_pkg::mag32(ar_ff);
            mul_b_req.b     = skf_pkg::mag32(ar_ff);
            neg_in          = ar_ff[FW-1] ^ mean_ext[FW-1];
            state_in        = S_PRED_WAIT;
         end
         S_PRED_WAIT: begin
            if (!mul_busy) begin
               at_in    = at_clip.value[FW-1:0];
               phi2_in  = phi2_clip.value[VW-1:0];
               sat_in   = sat_ff | at_clip.hit | phi2_clip.hit;
               state_in = S_VAR;
            end
         end
         S_VAR: begin
            // Issue phi^2 * v
            mul_a_req.start = 1'b1;
            mul_a_req.a     = {1'b0, phi2_ff};
            mul_a_req.b     = {1'b0, var_ff};
            state_in        = S_VAR_WAIT;
         end
         S_VAR_WAIT: begin
            if (!mul_busy) begin
               pt_in    = pt_clip.value[VW-1:0];
               vt_in    = vt_clip.value[FW-1:0];
               sat_in   = sat_ff | pt_clip.hit | vt_clip.hit;
               state_in = S_GAIN;
            end
         end
         S_GAIN: begin
            // Issue |vt|*pt and pt*pt, form the denominator
            mul_a_req.start = 1'b1;
            mul_a_req.a     = skf_pkg::mag32(vt_ff);
            mul_a_req.b     = {1'b0, pt_ff};
            mul_b_req.start = 1'b1;
            mul_b_req.a     = {1'b0, pt_ff};
            mul_b_req.b     = {1'b0, pt_ff};
            den_in          = {1'b0, pt_ff} + {1'b0, rnoise_ff};
            state_in        = S_GAIN_WAIT;
         end
         S_GAIN_WAIT: begin
            // Zero denominator skips the division
            if (!mul_busy) begin
               if (den_ff == '0) begin
                  dz_in    = 1'b1;
                  state_in = S_FIN;
               end else begin
                  state_in = S_DIV;
               end
            end
         end
         S_DIV: begin
            div_a_req.start    = 1'b1;
            div_a_req.dividend = mul_a_rsp.product;
            div_a_req.divisor  = den_ff;
            div_b_req.start    = 1'b1;
            div_b_req.dividend = mul_b_rsp.product;
            div_b_req.divisor  = den_ff;
            state_in           = S_DIV_WAIT;
         end
         S_DIV_WAIT: begin
            if (!div_busy) begin
               state_in = S_FIN;
            end
         end
         S_FIN: begin
            // Hold until the output register frees, then commit the state
            if (out_free) begin
               mean_in      = newm_clip.value[SAT_W-1:0];
               var_in       = newv;
               rsp_valid_in = 1'b1;
               rsp_mean_in  = newm_clip.value[FW-1:0];
               rsp_var_in   = newv;
               rsp_sat_in   = sat_ff | newm_clip.hit;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         ar_ff        <= '0;
         ofs_ff       <= '0;
         rnoise_ff    <= skf_pkg::VAR_RESET;
         qnoise_ff    <= skf_pkg::VAR_RESET;
         mean_ff      <= '0;
         var_ff       <= skf_pkg::VAR_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ar_ff        <= ar_in;
         ofs_ff       <= ofs_in;
         rnoise_ff    <= rnoise_in;
         qnoise_ff    <= qnoise_in;
         mean_ff      <= mean_in;
         var_ff       <= var_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      y_ff        <= y_in;
      at_ff       <= at_in;
      vt_ff       <= vt_in;
      phi2_ff     <= phi2_in;
      pt_ff       <= pt_in;
      den_ff      <= den_in;
      dz_ff       <= dz_in;
      neg_ff      <= neg_in;
      sat_ff      <= sat_in;
      rsp_mean_ff <= rsp_mean_in;
      rsp_var_ff  <= rsp_var_in;
      rsp_sat_ff  <= rsp_sat_in;
   end

   assign req_chan.ready         = (state_ff == S_IDLE);
   assign csr_chan.ready         = 1'b1;
   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.filtered_mean = rsp_mean_ff;
   assign rsp_chan.filtered_var  = rsp_var_ff;
   assign rsp_chan.saturated     = rsp_sat_ff;

endmodule

// ===== hw/rtl/skf_checker.sv =====
// Port-level checks of the scalar Kalman filter and their bind to the top level.
// Depends on skf_pkg and scalar_kalman_filter_unit.
module skf_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_valid,
   input logic                         req_ready,
   input logic                         rsp_valid,
   input logic                         rsp_ready,
   input logic [skf_pkg::FIELD_W-1:0]  rsp_mean,
   input logic [skf_pkg::VAR_W-1:0]    rsp_var,
   input logic                         rsp_sat
);

   logic       req_xfer;
   logic       rsp_xfer;
   logic [1:0] outstanding_ff, outstanding_in;

   // Count items accepted and not yet delivered
   assign req_xfer       = req_valid & req_ready;
   assign rsp_xfer       = rsp_valid & rsp_ready;
   assign outstanding_in = outstanding_ff + 2'(req_xfer) - 2'(rsp_xfer);

   always_ff @(posedge clock) begin
      if (reset) begin
         outstanding_ff <= '0;
      end else begin
         outstanding_ff <= outstanding_in;
      end
   end

   // A result waiting for the receiver stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("rsp valid dropped before transfer");

   // A stalled result keeps its payload
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_mean) && $stable(rsp_var) && $stable(rsp_sat))
      else $error("rsp payload changed while stalled");

   // After taking an item the filter is busy on it
   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      req_xfer |=> !req_ready)
      else $error("req accepted again right after a transfer");

   // No result without an item behind it
   a_no_spurious_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> outstanding_ff != 2'd0)
      else $error("rsp offered with no item outstanding");

   // At most one item in the arithmetic and one in the output register
   a_depth: assert property (@(posedge clock) disable iff (reset)
      outstanding_ff != 2'd3)
      else $error("more than two items outstanding");

endmodule

bind scalar_kalman_filter_unit skf_checker u_skf_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_chan.valid),
   .req_ready (req_chan.ready),
   .rsp_valid (rsp_chan.valid),
   .rsp_ready (rsp_chan.ready),
   .rsp_mean  (rsp_chan.filtered_mean),
   .rsp_var   (rsp_chan.filtered_var),
   .rsp_sat   (rsp_chan.saturated)
);

// ===== dv/scalar_kalman_filter_unit_tb.sv =====
// Self-checking testbench for scalar_kalman_filter_unit: drives observations
// and register writes, predicts each filtered estimate and checks every result.
// Depends on skf_pkg, the three channel interfaces and the filter unit.
`timescale 1ns / 1ps

module scalar_kalman_filter_unit_tb;

   localparam int DATA_WIDTH   = skf_pkg::DATA_WIDTH_DEF;
   localparam int FIELD_W      = skf_pkg::FIELD_W;
   localparam int VAR_W        = skf_pkg::VAR_W;
   localparam int CSR_IDX_W    = skf_pkg::CSR_IDX_W;
   localparam int SAT_W        = (DATA_WIDTH < 32) ? DATA_WIDTH : 32;
   localparam logic signed [63:0] MEAN_HI = (64'sd1 <<< (SAT_W - 1)) - 64'sd1;
   localparam logic signed [63:0] MEAN_LO = -MEAN_HI - 64'sd1;
   localparam logic signed [63:0] VAR_HI  = MEAN_HI;
   localparam logic signed [FIELD_W-1:0] OBS_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [FIELD_W-1:0] OBS_MIN = 32'sh8000_0000;
   localparam logic [VAR_W-1:0] NOISE_MAX = {VAR_W{1'b1}};
   localparam int ONE_Q16      = 65536;
   localparam int IDLE_LIMIT   = 4000;
   localparam int DRAIN_CYCLES = 120;
   localparam int PHASE_ITEMS  = 230;

   typedef struct packed {
      logic signed [FIELD_W-1:0] observation;
      logic                      series_start;
   } sample_type;

   typedef struct packed {
      logic [CSR_IDX_W-1:0] index;
      logic [FIELD_W-1:0]   wdata;
   } reg_write_type;

   typedef struct packed {
      logic signed [FIELD_W-1:0] mean;
      logic [VAR_W-1:0]          variance;
      logic                      clipped;
   } estimate_type;

   logic clock;
   logic reset;

   skf_req_if req_if ();
   skf_rsp_if rsp_if ();
   skf_csr_if csr_if ();

   scalar_kalman_filter_unit #(
      .DATA_WIDTH(DATA_WIDTH)
   ) i_dut (
      .clock   (clock),
      .reset   (reset),
      .req_chan(req_if),
      .rsp_chan(rsp_if),
      .csr_chan(csr_if)
   );

   // Stimulus and expectation stores
   sample_type    sample_queue[$];
   reg_write_type reg_write_queue[$];
   estimate_type  estimate_queue[$];

   // Filter registers and state as the checker tracks them
   logic signed [FIELD_W-1:0] phi_reg;
   logic signed [FIELD_W-1:0] offset_reg;
   logic [VAR_W-1:0]          obs_noise_reg;
   logic [VAR_W-1:0]          state_noise_reg;
   logic signed [63:0]        track_mean;
   logic signed [63:0]        track_var;
   logic                      step_clipped;

   logic        req_taken;
   logic        csr_taken;
   int unsigned sender_idle_pct;
   int unsigned receiver_stall_pct;
   int          fail_count;
   int          idle_cycles;

   // Clock
   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Limit a value and note any clip for this step
   function automatic logic signed [63:0] clip_to(input logic signed [63:0] x,
                                                  input logic signed [63:0] lo,
                                                  input logic signed [63:0] hi);
      if (x < lo) begin
         step_clipped = 1'b1;
         return lo;
      end
      if (x > hi) begin
         step_clipped = 1'b1;
         return hi;
      end
      return x;
   endfunction

   // One filter update: predict, form the innovation, apply the gain
   function automatic estimate_type filter_step(input logic signed [FIELD_W-1:0] y_in,
                                                input logic start);
      logic signed [63:0] y, ofs, phi, q, r, pred_mean, phi_sq, pred_var;
      logic signed [63:0] innov, denom, gain_term, new_mean, new_var;
      logic [63:0]        abs_innov, pred_var_u, denom_u, quo;
      estimate_type       e;
      step_clipped = 1'b0;
      y   = 64'(y_in);
      ofs = 64'(offset_reg);
      phi = 64'(phi_reg);
      q   = {33'b0, state_noise_reg};
      r   = {33'b0, obs_noise_reg};
      // reload the prior at the head of a series
      if (start) begin
         track_mean = 64'sd0;
         track_var  = clip_to(q, 64'sd0, VAR_HI);
      end
      pred_mean = clip_to((phi * track_mean) >>> 16, MEAN_LO, MEAN_HI);
      phi_sq    = clip_to((phi * phi) >>> 16, 64'sd0, VAR_HI);
      pred_var  = clip_to(((phi_sq * track_var) >>> 16) + q, 64'sd0, VAR_HI);
      innov     = clip_to(y - ofs - pred_mean, MEAN_LO, MEAN_HI);
      denom     = pred_var + r;
      // zero denominator leaves the prediction untouched
      if (denom > 64'sd0) begin
         abs_innov  = (innov < 64'sd0) ? -innov : innov;
         pred_var_u = pred_var;
         denom_u    = denom;
         quo        = (abs_innov * pred_var_u) / denom_u;
         gain_term  = (innov < 64'sd0) ? -$signed(quo) : $signed(quo);
         new_var    = pred_var - $signed((pred_var_u * pred_var_u) / denom_u);
      end else begin
         gain_term = 64'sd0;
         new_var   = pred_var;
      end
      new_mean   = clip_to(pred_mean + gain_term, MEAN_LO, MEAN_HI);
      track_mean = new_mean;
      track_var  = new_var;
      e.mean     = new_mean[FIELD_W-1:0];
      e.variance = new_var[VAR_W-1:0];
      e.clipped  = step_clipped;
      return e;
   endfunction

   // Register write as the block applies it
   function automatic void apply_register(input logic [CSR_IDX_W-1:0] idx,
                                          input logic [FIELD_W-1:0] value);
      case (idx)
         skf_pkg::CSR_AR_COEF:   phi_reg         = value;
         skf_pkg::CSR_MEAN_OFS:  offset_reg      = value;
         skf_pkg::CSR_OBS_NOISE: obs_noise_reg   = value[VAR_W-1:0];
         skf_pkg::CSR_STA_NOISE: state_noise_reg = value[VAR_W-1:0];
         default: ;
      endcase
   endfunction

   task automatic report(input string field, input logic [63:0] want,
                         input logic [63:0] got);
      $display("%0t: %s mismatch: expected %0h, actual %0h", $time, field, want, got);
      fail_count++;
   endtask

   // Driver: advance inputs at the falling edge
   always @(negedge clock) begin
      sample_type    s;
      reg_write_type w;
      if (reset) begin
         req_if.valid <= 1'b0;
         csr_if.valid <= 1'b0;
         rsp_if.ready <= 1'b0;
      end else begin
         // hold an observation until its transfer, then maybe idle
         if (req_if.valid && !req_taken) begin
         end else if (sample_queue.size() != 0 &&
                      $urandom_range(99) >= sender_idle_pct) begin
            s = sample_queue.pop_front();
            req_if.valid        <= 1'b1;
            req_if.observation  <= s.observation;
            req_if.series_start <= s.series_start;
         end else begin
            req_if.valid <= 1'b0;
         end
         // register writes go out back to back
         if (csr_if.valid && !csr_taken) begin
         end else if (reg_write_queue.size() != 0) begin
            w = reg_write_queue.pop_front();
            csr_if.valid <= 1'b1;
            csr_if.index <= w.index;
            csr_if.wdata <= w.wdata;
         end else begin
            csr_if.valid <= 1'b0;
         end
         rsp_if.ready <= ($urandom_range(99) >= receiver_stall_pct);
      end
   end

   // Monitor: sample transfers at the rising edge, predict and check
   always @(posedge clock) begin
      estimate_type want;
      logic         moved;
      if (!reset) begin
         moved = 1'b0;
         if (csr_if.valid && csr_if.ready) begin
            apply_register(csr_if.index, csr_if.wdata);
            moved = 1'b1;
         end
         if (req_if.valid && req_if.ready) begin
            estimate_queue.push_back(filter_step(req_if.observation, req_if.series_start));
            moved = 1'b1;
         end
         if (rsp_if.valid && rsp_if.ready) begin
            moved = 1'b1;
            if (estimate_queue.size() == 0) begin
               $display("%0t: result with no estimate pending: mean %0h, var %0h",
                        $time, rsp_if.filtered_mean, rsp_if.filtered_var);
               fail_count++;
            end else begin
               want = estimate_queue.pop_front();
               if (rsp_if.filtered_mean !== want.mean)
                  report("filtered_mean", 64'(want.mean), 64'(rsp_if.filtered_mean));
               if (rsp_if.filtered_var !== want.variance)
                  report("filtered_var", 64'(want.variance), 64'(rsp_if.filtered_var));
               if (rsp_if.saturated !== want.clipped)
                  report("saturated", 64'(want.clipped), 64'(rsp_if.saturated));
            end
         end
         req_taken <= req_if.valid && req_if.ready;
         csr_taken <= csr_if.valid && csr_if.ready;
         // watchdog on cycles without any transfer
         if (moved) begin
            idle_cycles <= 0;
         end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
            $display("%0t: no transfer for %0d cycles", $time, IDLE_LIMIT);
            $display("RESULT: ERROR");
            $finish;
         end else begin
            idle_cycles <= idle_cycles + 1;
         end
      end
   end

   task automatic push_sample(input logic signed [FIELD_W-1:0] y, input logic start);
      sample_type s;
      s.observation  = y;
      s.series_start = start;
      sample_queue.push_back(s);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [FIELD_W-1:0] value);
      reg_write_type w;
      w.index = idx;
      w.wdata = value;
      reg_write_queue.push_back(w);
   endtask

   // Wait until every queued transfer is done and every estimate has come back
   task automatic settle();
      while (sample_queue.size() != 0 || reg_write_queue.size() != 0 ||
             req_if.valid || csr_if.valid || estimate_queue.size() != 0)
         @(negedge clock);
   endtask

   task automatic configure(input logic [FIELD_W-1:0] phi, input logic [FIELD_W-1:0] ofs,
                            input logic [VAR_W-1:0] r, input logic [VAR_W-1:0] q);
      settle();
      write_reg(skf_pkg::CSR_AR_COEF, phi);
      write_reg(skf_pkg::CSR_MEAN_OFS, ofs);
      write_reg(skf_pkg::CSR_OBS_NOISE, {1'b0, r});
      write_reg(skf_pkg::CSR_STA_NOISE, {1'b0, q});
      settle();
   endtask

   function automatic logic signed [FIELD_W-1:0] pick_observation();
      int unsigned roll;
      roll = $urandom_range(99);
      if (roll < 65)
         return offset_reg + (int'($urandom_range(1 << 21)) - (1 << 20));
      if (roll < 90)
         return $urandom();
      case ($urandom_range(3))
         0:       return OBS_MAX;
         1:       return OBS_MIN;
         2:       return '0;
         default: return '1;
      endcase
   endfunction

   function automatic logic [FIELD_W-1:0] pick_coefficient();
      int unsigned roll;
      roll = $urandom_range(99);
      if (roll < 60)
         return int'($urandom_range(3 * ONE_Q16)) - (3 * ONE_Q16) / 2;
      if (roll < 85)
         return $urandom();
      case ($urandom_range(3))
         0:       return OBS_MAX;
         1:       return OBS_MIN;
         2:       return '0;
         default: return ONE_Q16;
      endcase
   endfunction

   function automatic logic [FIELD_W-1:0] pick_offset();
      if ($urandom_range(99) < 70)
         return int'($urandom_range(1 << 21)) - (1 << 20);
      return $urandom();
   endfunction

   function automatic logic [VAR_W-1:0] pick_noise();
      int unsigned roll;
      roll = $urandom_range(99);
      if (roll < 60)
         return VAR_W'($urandom_range(1 << 20, 1));
      if (roll < 80)
         return VAR_W'($urandom());
      if (roll < 90)
         return '0;
      return NOISE_MAX;
   endfunction

   // Queue well-formed series with random content and a little noise on the flag
   task automatic queue_series(input int n);
      int  left;
      int  len;
      logic start;
      left = n;
      while (left > 0) begin
         len = $urandom_range(40, 1);
         if (len > left)
            len = left;
         for (int i = 0; i < len; i++) begin
            start = (i == 0);
            if ($urandom_range(99) < 8)
               start = 1'($urandom_range(1));
            push_sample(pick_observation(), start);
         end
         left -= len;
      end
   endtask

   // Random phase, with one full drain halfway through
   task automatic random_phase(input int n, input int unsigned idle_pct,
                               input int unsigned stall_pct);
      settle();
      sender_idle_pct    = idle_pct;
      receiver_stall_pct = stall_pct;
      queue_series(n / 2);
      settle();
      queue_series(n - n / 2);
      settle();
   endtask

   // Sequence: reset, directed cases, random phases, drain, verdict
   initial begin
      int unsigned idle_sel[6];
      int unsigned stall_sel[6];
      idle_sel  = '{0, 58, 0, 23, 58, 0};
      stall_sel = '{0, 0, 58, 23, 0, 58};

      reset               = 1'b1;
      req_if.valid        = 1'b0;
      req_if.observation  = '0;
      req_if.series_start = 1'b0;
      rsp_if.ready        = 1'b0;
      csr_if.valid        = 1'b0;
      csr_if.index        = '0;
      csr_if.wdata        = '0;
      req_taken           = 1'b0;
      csr_taken           = 1'b0;
      sender_idle_pct     = 0;
      receiver_stall_pct  = 0;
      fail_count          = 0;
      idle_cycles         = 0;
      phi_reg             = '0;
      offset_reg          = '0;
      obs_noise_reg       = skf_pkg::VAR_RESET;
      state_noise_reg     = skf_pkg::VAR_RESET;
      track_mean          = 64'sd0;
      track_var           = 64'(skf_pkg::VAR_RESET);

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset state as prior, then field extremes with default registers
      push_sample(ONE_Q16, 1'b0);
      push_sample(OBS_MAX, 1'b0);
      push_sample(OBS_MIN, 1'b1);
      push_sample('1, 1'b0);
      push_sample('0, 1'b1);

      // typical decay with an offset
      configure(3 * ONE_Q16 / 4, 2 * ONE_Q16, VAR_W'(ONE_Q16), VAR_W'(ONE_Q16 / 2));
      push_sample(3 * ONE_Q16, 1'b1);
      push_sample(5 * ONE_Q16 / 2, 1'b0);
      push_sample(OBS_MAX, 1'b0);
      push_sample(OBS_MIN, 1'b0);

      // zero noise on both sides: zero denominator, gain forced to zero
      configure(ONE_Q16, '0, '0, '0);
      push_sample(5 * ONE_Q16, 1'b1);
      push_sample(-5 * ONE_Q16, 1'b0);
      push_sample(OBS_MIN, 1'b0);

      // largest coefficient and noise: clips in the prediction stages
      configure(OBS_MAX, OBS_MIN, NOISE_MAX, NOISE_MAX);
      push_sample(OBS_MAX, 1'b1);
      push_sample(OBS_MIN, 1'b0);
      push_sample(OBS_MAX, 1'b0);
      push_sample('0, 1'b0);

      // most negative coefficient
      configure(OBS_MIN, OBS_MAX, VAR_W'(1), NOISE_MAX);
      push_sample(OBS_MIN, 1'b1);
      push_sample(OBS_MAX, 1'b0);
      push_sample('1, 1'b0);

      // write to an unused index must change nothing
      settle();
      write_reg(CSR_IDX_W'($urandom_range(2 ** CSR_IDX_W - 1, skf_pkg::CSR_STA_NOISE + 1)),
                $urandom());
      settle();
      push_sample(ONE_Q16, 1'b0);
      settle();

      // random phases over a range of register settings
      for (int p = 0; p < 6; p++) begin
         case (p)
            0:       configure(OBS_MAX, OBS_MIN, NOISE_MAX, NOISE_MAX);
            1:       configure(OBS_MIN, OBS_MAX, '0, pick_noise());
            default: configure(pick_coefficient(), pick_offset(), pick_noise(), pick_noise());
         endcase
         random_phase(PHASE_ITEMS, idle_sel[p], stall_sel[p]);
      end

      settle();
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (fail_count == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule
